// ===== rtl/sacs_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo angle command slewer package
// Shared constants, codes and types for the command parser and slew engine.
// ----------------------------------------------------------------------------
package sacs_pkg;

   localparam int NUM_CHANNELS = 7;
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] ANGLE_MAX   = 8'd180;
   localparam logic [7:0] ANGLE_RESET = 8'd90;
   localparam logic [7:0] ACC_CAP     = 8'd181;

   localparam logic [15:0] PULSE_MIN_RESET  = 16'd500;
   localparam logic [15:0] PULSE_SPAN_RESET = 16'd2000;

   // Division by 180 of a product below 2^24 is exact as (x * RECIP_180) >> 32.
   localparam int          PROD_W      = 24;
   localparam int          RECIP_W     = 25;
   localparam int          RECIP_SHIFT = 32;
   localparam logic [RECIP_W-1:0] RECIP_180 = 25'd23860930;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PULSE_MIN  = 2'd0,
      CSR_PULSE_SPAN = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_FRAME = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      PH_LEAD   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_TICK = 1'b1
   } back_state_type;

   typedef logic [NUM_CHANNELS-1:0][7:0] angle_vec_type;

   typedef struct packed {
      logic              is_tick;
      logic [CNT_W-1:0]  count;
      angle_vec_type     values;
   } cmd_type;

   typedef struct packed {
      logic [15:0] pulse_min;
      logic [15:0] pulse_span;
   } cfg_type;

endpackage

// ===== rtl/sacs_channels.sv =====
// ----------------------------------------------------------------------------
// Servo angle command slewer channels
// Valid/ready channel interfaces for received items and channel results.
// ----------------------------------------------------------------------------
interface sacs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface sacs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  channel;
   logic [7:0]  angle;
   logic [15:0] pulse_width;
   logic        moved;
   logic        last;

   modport source (output valid, output channel, output angle, output pulse_width,
                   output moved, output last, input ready);
   modport sink (input valid, input channel, input angle, input pulse_width,
                 input moved, input last, output ready);
endinterface

// ===== rtl/servo_angle_command_slewer.sv =====
// A slew tick passes the command queue, the engine state register and the s1, s2 and
// result registers before its first channel result, then one result per cycle while
// the result side takes them. One received byte or, while the command queue has room,
// frame end per cycle; a tick steps the seven channels through one pulse-width unit.
// Reset is synchronous and active high: all angles and targets return to 90 degrees,
// the pulse registers to 500 and 2000, the parser and command queue are emptied.
// ----------------------------------------------------------------------------
// Servo angle command slewer
// Parses comma-separated angle messages and slews seven servo channels.
// ----------------------------------------------------------------------------
module servo_angle_command_slewer
   import sacs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   sacs_req_if.sink                req_chan,
   sacs_rsp_if.source              rsp_chan,
   input  logic                    csr_wen,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]             csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     cmd_push;
   cmd_type  cmd_data;
   logic     cmd_pop;
   cmd_type  cmd_head;
   logic     cmd_full;
   logic     cmd_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_PULSE_MIN: begin
               cfg_in.pulse_min = csr_wdata;
            end
            CSR_PULSE_SPAN: begin
               cfg_in.pulse_span = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_min  <= PULSE_MIN_RESET;
         cfg_ff.pulse_span <= PULSE_SPAN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sacs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data)
   );

   sacs_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .full      (cmd_full),
      .empty     (cmd_empty)
   );

   sacs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== rtl/sacs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Servo angle command slewer command queue
// Short register queue of frame and tick commands between parser and engine.
// ----------------------------------------------------------------------------
module sacs_cmd_fifo
   import sacs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type                 entry_ff [FIFO_DEPTH];
   cmd_type                 entry_in [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full    = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/sacs_front.sv =====
// ----------------------------------------------------------------------------
// Servo angle command slewer front end
// Parses received bytes into pending angles and queues frame and tick commands.
// ----------------------------------------------------------------------------
module sacs_front
   import sacs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sacs_req_if.sink  req_chan,
   input  logic      cmd_full,
   output logic      cmd_push,
   output cmd_type   cmd_data
);

   phase_type        phase_ff, phase_in;
   logic [7:0]       acc_ff, acc_in;
   logic             seen_ff, seen_in;
   logic             neg_ff, neg_in;
   logic             stopped_ff, stopped_in;
   logic [CNT_W-1:0] count_ff, count_in;
   angle_vec_type    pending_ff, pending_in;

   op_type           op;
   logic             accept;
   logic             digit;
   logic             blank;
   logic [7:0]       digit_val;
   logic [10:0]      acc_mul;
   logic [7:0]       close_val;
   logic             close_wr;
   logic             close;
   logic             frame;

   assign op             = op_type'(req_chan.op);
   assign req_chan.ready = !(cmd_full && (op == OP_FRAME || op == OP_TICK));
   assign accept         = req_chan.valid && req_chan.ready;

   assign digit     = (req_chan.data_byte >= CHAR_ZERO) && (req_chan.data_byte <= CHAR_NINE);
   assign blank     = (req_chan.data_byte == CHAR_SPACE) ||
                      ((req_chan.data_byte >= CHAR_TAB) && (req_chan.data_byte <= CHAR_CR));
   assign digit_val = req_chan.data_byte - CHAR_ZERO;
   assign acc_mul   = 11'(acc_ff) * 11'd10 + 11'(digit_val);
   assign close_val = neg_ff ? 8'd0 : ((acc_ff > ANGLE_MAX) ? ANGLE_MAX : acc_ff);
   assign close_wr  = seen_ff && (count_ff < CNT_W'(NUM_CHANNELS));

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      seen_in    = seen_ff;
      neg_in     = neg_ff;
      stopped_in = stopped_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      close      = 1'b0;
      frame      = 1'b0;
      cmd_push   = 1'b0;
      cmd_data.is_tick = 1'b0;

      if (accept) begin
         case (op)
            OP_BYTE: begin
               if (!stopped_ff) begin
                  if (req_chan.data_byte == CHAR_NUL) begin
                     stopped_in = 1'b1;
                  end else if (req_chan.data_byte == CHAR_COMMA) begin
                     close = 1'b1;
                  end else begin
                     seen_in = 1'b1;
                     case (phase_ff)
                        PH_LEAD: begin
                           if (blank) begin
                              phase_in = PH_LEAD;
                           end else if (req_chan.data_byte == CHAR_PLUS ||
                                        req_chan.data_byte == CHAR_MINUS) begin
                              neg_in   = (req_chan.data_byte == CHAR_MINUS);
                              phase_in = PH_SIGN;
                           end else if (digit) begin
                              acc_in   = digit_val;
                              phase_in = PH_DIGITS;
                           end else begin
                              phase_in = PH_DONE;
                           end
                        end
                        PH_SIGN: begin
                           if (digit) begin
                              acc_in   = digit_val;
                              phase_in = PH_DIGITS;
                           end else begin
                              phase_in = PH_DONE;
                           end
                        end
                        PH_DIGITS: begin
                           if (digit) begin
                              acc_in = (acc_mul > 11'(ACC_CAP)) ? ACC_CAP : acc_mul[7:0];
                           end else begin
                              phase_in = PH_DONE;
                           end
                        end
                        default: begin
                           phase_in = phase_ff;
                        end
                     endcase
                  end
               end
            end
            OP_FRAME: begin
               close      = 1'b1;
               frame      = 1'b1;
               cmd_push   = 1'b1;
               stopped_in = 1'b0;
            end
            OP_TICK: begin
               cmd_push         = 1'b1;
               cmd_data.is_tick = 1'b1;
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end

      if (close) begin
         if (close_wr) begin
            pending_in[count_ff[CH_W-1:0]] = close_val;
            count_in = count_ff + 1'b1;
         end
         acc_in   = '0;
         phase_in = PH_LEAD;
         seen_in  = 1'b0;
         neg_in   = 1'b0;
      end

      cmd_data.count  = count_in;
      cmd_data.values = pending_in;
      if (frame) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEAD;
         acc_ff     <= '0;
         seen_ff    <= 1'b0;
         neg_ff     <= 1'b0;
         stopped_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         seen_ff    <= seen_in;
         neg_ff     <= neg_in;
         stopped_ff <= stopped_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff <= pending_in;
   end

endmodule

// ===== rtl/sacs_back.sv =====
// ----------------------------------------------------------------------------
// Servo angle command slewer back end
// Applies frame targets and slews each channel, computing its pulse width.
// ----------------------------------------------------------------------------
module sacs_back
   import sacs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        cmd_empty,
   input  cmd_type     cmd_head,
   output logic        cmd_pop,
   sacs_rsp_if.source  rsp_chan
);

   back_state_type     state_ff, state_in;
   logic [CH_W-1:0]    ch_ff, ch_in;
   angle_vec_type      target_ff, target_in;
   angle_vec_type      current_ff, current_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0]  s1_prod_ff;
   logic [7:0]         s1_angle_ff;
   logic               s1_moved_ff;
   logic               s1_last_ff;
   logic [CH_W-1:0]    s1_ch_ff;

   logic               s2_valid_ff, s2_valid_in;
   logic [15:0]        s2_quot_ff;
   logic [7:0]         s2_angle_ff;
   logic               s2_moved_ff;
   logic               s2_last_ff;
   logic [CH_W-1:0]    s2_ch_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_channel_ff;
   logic [7:0]         rsp_angle_ff;
   logic [15:0]        rsp_pulse_ff;
   logic               rsp_moved_ff;
   logic               rsp_last_ff;

   logic               adv;
   logic               issue;
   logic               apply;
   logic [7:0]         cur;
   logic [7:0]         tgt;
   logic [7:0]         new_angle;
   logic               new_moved;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W+RECIP_W-1:0] recip_mul;
   logic [16:0]        pulse_sum;

   assign adv = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && cmd_head.is_tick) begin
               state_in = BK_TICK;
            end
         end
         BK_TICK: begin
            if (adv && ch_ff == CH_W'(NUM_CHANNELS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop = 1'b0;
      apply   = 1'b0;
      issue   = 1'b0;
      ch_in   = ch_ff;
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = !cmd_empty;
            apply   = !cmd_empty && !cmd_head.is_tick;
            ch_in   = '0;
         end
         BK_TICK: begin
            issue = adv;
            if (adv) begin
               ch_in = (ch_ff == CH_W'(NUM_CHANNELS - 1)) ? '0 : ch_ff + 1'b1;
            end
         end
         default: begin
            ch_in = '0;
         end
      endcase
   end

   always_comb begin
      cur       = current_ff[ch_ff];
      tgt       = target_ff[ch_ff];
      new_angle = cur;
      new_moved = 1'b0;
      if (cur < tgt) begin
         new_angle = cur + 8'd1;
         new_moved = 1'b1;
      end else if (cur > tgt) begin
         new_angle = cur - 8'd1;
         new_moved = 1'b1;
      end
      prod = PROD_W'(new_angle) * PROD_W'(cfg.pulse_span);

      current_in = current_ff;
      if (issue) begin
         current_in[ch_ff] = new_angle;
      end

      target_in = target_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (apply && (CNT_W'(i) < cmd_head.count)) begin
            target_in[i] = cmd_head.values[i];
         end
      end
   end

   assign recip_mul = (PROD_W + RECIP_W)'(s1_prod_ff) * (PROD_W + RECIP_W)'(RECIP_180);
   assign pulse_sum = 17'(cfg.pulse_min) + 17'(s2_quot_ff);

   assign s1_valid_in  = adv ? issue : s1_valid_ff;
   assign s2_valid_in  = adv ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = adv ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ch_ff        <= '0;
         target_ff    <= {NUM_CHANNELS{ANGLE_RESET}};
         current_ff   <= {NUM_CHANNELS{ANGLE_RESET}};
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         target_ff    <= target_in;
         current_ff   <= current_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff     <= prod;
         s1_angle_ff    <= new_angle;
         s1_moved_ff    <= new_moved;
         s1_last_ff     <= (ch_ff == CH_W'(NUM_CHANNELS - 1));
         s1_ch_ff       <= ch_ff;
         s2_quot_ff     <= recip_mul[RECIP_SHIFT+15:RECIP_SHIFT];
         s2_angle_ff    <= s1_angle_ff;
         s2_moved_ff    <= s1_moved_ff;
         s2_last_ff     <= s1_last_ff;
         s2_ch_ff       <= s1_ch_ff;
         rsp_channel_ff <= 3'(s2_ch_ff);
         rsp_angle_ff   <= s2_angle_ff;
         rsp_pulse_ff   <= pulse_sum[16] ? 16'hFFFF : pulse_sum[15:0];
         rsp_moved_ff   <= s2_moved_ff;
         rsp_last_ff    <= s2_last_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.channel     = rsp_channel_ff;
   assign rsp_chan.angle       = rsp_angle_ff;
   assign rsp_chan.pulse_width = rsp_pulse_ff;
   assign rsp_chan.moved       = rsp_moved_ff;
   assign rsp_chan.last        = rsp_last_ff;

endmodule

// ===== tb/tb_servo_angle_command_slewer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo angle command slewer testbench
// Sends received bytes, frame ends and slew ticks with random gaps on both
// channels, predicts every channel result from its own copy of the parser and
// slew state, and compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
module tb_servo_angle_command_slewer
   import sacs_pkg::*;
();

   localparam logic [1:0]             OP_SPARE     = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam int MAX_GAP      = 11;
   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PRINT_LIMIT  = 30;

   typedef struct {
      logic [2:0]  channel;
      logic [7:0]  angle;
      logic [15:0] pulse_width;
      logic        moved;
      logic        last;
   } servo_report_type;

   logic clock;
   logic reset;
   logic csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [15:0] csr_wdata;

   sacs_req_if req_chan();
   sacs_rsp_if rsp_chan();

   servo_angle_command_slewer uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted state of the parser and the slew engine.
   logic [15:0] cfg_min;
   logic [15:0] cfg_span;
   logic [7:0]  goal_angle [NUM_CHANNELS];
   logic [7:0]  servo_angle [NUM_CHANNELS];
   logic [7:0]  staged_value [NUM_CHANNELS];
   int          staged_count;
   logic [7:0]  digit_acc;
   phase_type   scan_phase;
   logic        token_open;
   logic        token_negative;
   logic        message_halted;

   servo_report_type expected_reports[$];
   logic [7:0]       message_bytes[$];

   int  cycle_count;
   int  error_count;
   int  items_sent;
   int  bytes_sent;
   int  frames_sent;
   int  ticks_sent;
   int  spare_sent;
   int  results_checked;
   int  csr_writes;
   bit  sender_idles;
   bit  receiver_idles;
   bit  stall_request;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run exceeded %0d cycles.", CYCLE_LIMIT);
         $display("servo_angle_command_slewer: mismatch");
         $finish;
      end
   end

   task automatic report_mismatch(string field, int got, int want);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("Error at result %0d: %s is %0d, expected %0d.",
                  results_checked, field, got, want);
      end
   endtask

   function automatic void reset_prediction();
      cfg_min  = PULSE_MIN_RESET;
      cfg_span = PULSE_SPAN_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         goal_angle[i]   = ANGLE_RESET;
         servo_angle[i]  = ANGLE_RESET;
         staged_value[i] = 8'd0;
      end
      staged_count   = 0;
      message_halted = 1'b0;
      digit_acc      = 8'd0;
      scan_phase     = PH_LEAD;
      token_open     = 1'b0;
      token_negative = 1'b0;
   endfunction

   function automatic void finish_token();
      logic [7:0] v;
      if (token_open && staged_count < NUM_CHANNELS) begin
         v = (digit_acc > ANGLE_MAX) ? ANGLE_MAX : digit_acc;
         if (token_negative) begin
            v = 8'd0;
         end
         staged_value[staged_count] = v;
         staged_count++;
      end
      digit_acc      = 8'd0;
      scan_phase     = PH_LEAD;
      token_open     = 1'b0;
      token_negative = 1'b0;
   endfunction

   function automatic void scan_char(logic [7:0] c);
      logic is_digit;
      int   next_acc;
      is_digit   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      token_open = 1'b1;
      case (scan_phase)
         PH_LEAD: begin
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               token_negative = (c == CHAR_MINUS);
               scan_phase     = PH_SIGN;
            end else if (is_digit) begin
               digit_acc  = c - CHAR_ZERO;
               scan_phase = PH_DIGITS;
            end else begin
               scan_phase = PH_DONE;
            end
         end
         PH_SIGN: begin
            if (is_digit) begin
               digit_acc  = c - CHAR_ZERO;
               scan_phase = PH_DIGITS;
            end else begin
               scan_phase = PH_DONE;
            end
         end
         PH_DIGITS: begin
            if (is_digit) begin
               next_acc  = int'(digit_acc) * 10 + int'(c - CHAR_ZERO);
               digit_acc = (next_acc > int'(ACC_CAP)) ? ACC_CAP : 8'(next_acc);
            end else begin
               scan_phase = PH_DONE;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void predict_transfer(logic [1:0] op, logic [7:0] data);
      servo_report_type r;
      int unsigned      pw;
      case (op)
         OP_BYTE: begin
            if (!message_halted) begin
               if (data == CHAR_NUL) begin
                  message_halted = 1'b1;
               end else if (data == CHAR_COMMA) begin
                  finish_token();
               end else begin
                  scan_char(data);
               end
            end
         end
         OP_FRAME: begin
            finish_token();
            for (int i = 0; i < staged_count; i++) begin
               goal_angle[i] = staged_value[i];
            end
            staged_count   = 0;
            message_halted = 1'b0;
         end
         OP_TICK: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               r.moved = 1'b1;
               if (servo_angle[i] < goal_angle[i]) begin
                  servo_angle[i]++;
               end else if (servo_angle[i] > goal_angle[i]) begin
                  servo_angle[i]--;
               end else begin
                  r.moved = 1'b0;
               end
               pw = 32'(cfg_min) + (32'(servo_angle[i]) * 32'(cfg_span)) / 32'(ANGLE_MAX);
               r.channel     = 3'(i);
               r.angle       = servo_angle[i];
               r.pulse_width = (pw > 32'hFFFF) ? 16'hFFFF : 16'(pw);
               r.last        = (i == NUM_CHANNELS - 1);
               expected_reports.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      servo_report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_checked++;
         if (expected_reports.size() == 0) begin
            report_mismatch("unexpected channel", int'(rsp_chan.channel), -1);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_chan.channel !== want.channel)
               report_mismatch("channel", int'(rsp_chan.channel), int'(want.channel));
            if (rsp_chan.angle !== want.angle)
               report_mismatch("angle", int'(rsp_chan.angle), int'(want.angle));
            if (rsp_chan.pulse_width !== want.pulse_width)
               report_mismatch("pulse_width", int'(rsp_chan.pulse_width),
                               int'(want.pulse_width));
            if (rsp_chan.moved !== want.moved)
               report_mismatch("moved", int'(rsp_chan.moved), int'(want.moved));
            if (rsp_chan.last !== want.last)
               report_mismatch("last", int'(rsp_chan.last), int'(want.last));
         end
      end
   end

   // The receiver holds off for a long stretch when a stall is requested, or else, when idling is
   // enabled, waits a random number of cycles before each transfer.
   initial begin
      int wait_cycles;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (stall_request) begin
            stall_request = 1'b0;
            wait_cycles   = STALL_CYCLES;
         end else begin
            wait_cycles = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
         end
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   task automatic send_item(logic [1:0] op, logic [7:0] data);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.data_byte <= data;
      do @(posedge clock); while (!req_chan.ready);
      predict_transfer(op, data);
      items_sent++;
      case (op)
         OP_BYTE:  bytes_sent++;
         OP_FRAME: frames_sent++;
         OP_TICK:  ticks_sent++;
         default:  spare_sent++;
      endcase
   endtask

   task automatic send_message();
      foreach (message_bytes[k]) begin
         send_item(OP_BYTE, message_bytes[k]);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [15:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      csr_writes++;
      if (index == CSR_PULSE_MIN) begin
         cfg_min = value;
      end else if (index == CSR_PULSE_SPAN) begin
         cfg_span = value;
      end
   endtask

   task automatic set_pulse(logic [15:0] min_value, logic [15:0] span_value);
      wait_drained();
      write_csr(CSR_PULSE_MIN, min_value);
      write_csr(CSR_PULSE_SPAN, span_value);
   endtask

   function automatic void push_text(string s);
      for (int k = 0; k < s.len(); k++) begin
         message_bytes.push_back(s[k]);
      end
   endfunction

   function automatic void push_token();
      int          kind;
      int unsigned n;
      kind = $urandom_range(0, 19);
      n    = $urandom_range(0, 200);
      if (kind <= 8) begin
         push_text($sformatf("%0d", n));
      end else if (kind <= 10) begin
         push_text($sformatf("%0d", $urandom_range(0, 99999)));
      end else if (kind == 11) begin
         push_text($sformatf("-%0d", n));
      end else if (kind == 12) begin
         push_text($sformatf("+%0d", n));
      end else if (kind == 13) begin
         message_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE
                                 : 8'(CHAR_TAB + $urandom_range(0, 4)));
         push_text($sformatf("%0d", n));
      end else if (kind == 14) begin
         push_text($sformatf("%0d", n));
         if ($urandom_range(0, 1)) begin
            push_text(".");
         end else begin
            push_text("x5");
         end
      end else if (kind == 16) begin
         push_text($sformatf("q%0d", n));
      end else if (kind == 17) begin
         push_text($urandom_range(0, 1) ? "-" : "+");
      end else if (kind == 18) begin
         push_text($sformatf("- %0d", n));
      end else if (kind == 19) begin
         message_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void build_message();
      int tokens;
      message_bytes.delete();
      tokens = $urandom_range(0, 9);
      if ($urandom_range(0, 9) == 0) begin
         message_bytes.push_back(CHAR_COMMA);
      end
      for (int t = 0; t < tokens; t++) begin
         if (t > 0) begin
            message_bytes.push_back(CHAR_COMMA);
         end
         push_token();
      end
      if ($urandom_range(0, 9) == 0) begin
         message_bytes.push_back(CHAR_COMMA);
      end
      if ($urandom_range(0, 19) == 0) begin
         message_bytes.push_back(CHAR_NUL);
         push_token();
      end
   endfunction

   task automatic test_idle_ticks();
      repeat (2) send_item(OP_TICK, 8'h00);
   endtask

   // Empty tokens, a huge value, a negative value, a sign without digits,
   // leading white space with trailing letters, then a zero byte that hides
   // the rest of the message; an unused op code must be ignored.
   task automatic test_parser_cases();
      message_bytes.delete();
      push_text(",999,-4,+x,\t7q,,3");
      message_bytes.push_back(CHAR_NUL);
      message_bytes.push_back(8'hFF);
      push_text("9");
      send_message();
      send_item(OP_FRAME, 8'hFF);
      send_item(OP_SPARE, 8'hA5);
      send_item(OP_TICK, 8'h5A);
   endtask

   task automatic test_pulse_extremes();
      set_pulse(16'hFFFF, 16'hFFFF);
      send_item(OP_TICK, 8'h00);
      set_pulse(16'h0000, 16'h0000);
      send_item(OP_TICK, 8'h00);
      wait_drained();
      write_csr(CSR_SPARE_LO, 16'($urandom));
      write_csr(CSR_SPARE_HI, 16'($urandom));
      send_item(OP_TICK, 8'h00);
   endtask

   task automatic test_random_traffic(int budget);
      int stop_at;
      int ticks;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         build_message();
         send_message();
         if ($urandom_range(0, 15) == 0) begin
            send_item(OP_SPARE, 8'($urandom));
         end
         send_item(OP_FRAME, 8'($urandom));
         ticks = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 95)
                                              : $urandom_range(0, 3);
         repeat (ticks) send_item(OP_TICK, 8'($urandom));
      end
   endtask

   task automatic test_result_stall();
      wait_drained();
      receiver_idles = 1'b0;
      stall_request  = 1'b1;
      repeat (12) send_item(OP_TICK, 8'($urandom));
      wait_drained();
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_wen            = 1'b0;
      csr_index          = CSR_PULSE_MIN;
      csr_wdata          = 16'd0;
      req_chan.valid     = 1'b0;
      req_chan.op        = OP_BYTE;
      req_chan.data_byte = 8'd0;
      sender_idles       = 1'b1;
      receiver_idles     = 1'b1;
      stall_request      = 1'b0;
      reset_prediction();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_parser_cases();
      test_pulse_extremes();

      set_pulse(PULSE_MIN_RESET, PULSE_SPAN_RESET);
      test_random_traffic(100);
      set_pulse(16'h0000, 16'hFFFF);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      test_random_traffic(100);
      set_pulse(16'hFFFF, 16'hFFFF);
      sender_idles   = 1'b1;
      test_random_traffic(80);
      set_pulse(16'($urandom), 16'($urandom));
      receiver_idles = 1'b1;
      test_random_traffic(100);
      test_result_stall();
      receiver_idles = 1'b1;
      set_pulse(16'hFFFF, 16'h0000);
      test_random_traffic(30);

      wait_drained();
      $display("Sent %0d bytes, %0d frame ends, %0d ticks and %0d unused ops;",
               bytes_sent, frames_sent, ticks_sent, spare_sent);
      $display("checked %0d results after %0d register writes and one long stall.",
               results_checked, csr_writes);
      if (error_count == 0) begin
         $display("servo_angle_command_slewer: match");
      end else begin
         $display("servo_angle_command_slewer: mismatch");
      end
      $finish;
   end

endmodule
